// ===== rtl/gnpi_pkg.sv =====
package gnpi_pkg;

    localparam int HALF_SPAN = 128;
    localparam int TABLE_LEN = 2 * HALF_SPAN - 1;
    localparam int POS_W     = $clog2(TABLE_LEN);
    localparam int CMP_W     = (POS_W > 8) ? POS_W : 8;
    localparam int SUM_W     = CMP_W + 2;
    localparam int DIST_W    = 17;
    localparam int NUM_CH    = 3;

    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_PIXEL = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  entry_index;
        logic [15:0] entry_value;
        logic [7:0]  chan_a_in;
        logic [7:0]  chan_b_in;
        logic [7:0]  chan_c_in;
        logic [15:0] rand_a;
        logic [15:0] rand_b;
        logic [15:0] rand_c;
    } t_in_item;

    typedef struct packed {
        logic [7:0] chan_a_out;
        logic [7:0] chan_b_out;
        logic [7:0] chan_c_out;
    } t_out_item;

    // one transaction as it travels down the row of cells
    typedef struct packed {
        logic                               valid;
        t_mode                              mode;
        logic [7:0]                         idx;
        logic [15:0]                        value;
        logic [NUM_CH-1:0][7:0]             chan;
        logic [NUM_CH-1:0][15:0]            rnd;
        logic [NUM_CH-1:0][DIST_W-1:0]      best;
        logic [NUM_CH-1:0][POS_W-1:0]       pos;
        logic [NUM_CH-1:0]                  done;
    } t_token;

    function automatic logic [DIST_W-1:0] dist16(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return {1'b0, d};
    endfunction

endpackage

// ===== rtl/gnpi_cell.sv =====
module gnpi_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [gnpi_pkg::POS_W-1:0]  i_cell_idx,
    input  gnpi_pkg::t_token            i_tok,
    output gnpi_pkg::t_token            o_tok
);

    gnpi_pkg::t_token   r_tok;
    gnpi_pkg::t_token   n_tok;
    logic [15:0]        r_entry;
    logic               w_hit;

    assign w_hit = i_tok.valid && (i_tok.mode == gnpi_pkg::MODE_WRITE) &&
                   (gnpi_pkg::CMP_W'(i_tok.idx) == gnpi_pkg::CMP_W'(i_cell_idx));

    always_comb begin
        logic [gnpi_pkg::DIST_W-1:0] d;
        n_tok = i_tok;
        d     = '0;
        if (i_tok.valid && (i_tok.mode == gnpi_pkg::MODE_PIXEL)) begin
            for (int ch = 0; ch < gnpi_pkg::NUM_CH; ch++) begin
                d = gnpi_pkg::dist16(i_tok.rnd[ch], r_entry);
                if (!i_tok.done[ch]) begin
                    // ties move on to this entry
                    if (d <= i_tok.best[ch]) begin
                        n_tok.best[ch] = d;
                        n_tok.pos[ch]  = i_cell_idx;
                    end else begin
                        n_tok.done[ch] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && w_hit) begin
            r_entry <= i_tok.value;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/gnpi_out.sv =====
module gnpi_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gnpi_pkg::t_token     i_tok,
    input  logic                 i_out_ready,
    output logic                 o_adv,
    output logic                 o_out_valid,
    output gnpi_pkg::t_out_item  o_out_data
);

    logic                             r_valid;
    gnpi_pkg::t_out_item              r_data;
    logic [gnpi_pkg::NUM_CH-1:0][7:0] w_res;

    always_comb begin
        logic signed [gnpi_pkg::SUM_W-1:0] s;
        s = '0;
        for (int ch = 0; ch < gnpi_pkg::NUM_CH; ch++) begin
            s = $signed(gnpi_pkg::SUM_W'(i_tok.chan[ch])) +
                $signed(gnpi_pkg::SUM_W'(i_tok.pos[ch])) -
                $signed(gnpi_pkg::SUM_W'(gnpi_pkg::HALF_SPAN - 1));
            if (s[gnpi_pkg::SUM_W-1]) begin
                w_res[ch] = 8'd0;
            end else if (s > $signed(gnpi_pkg::SUM_W'(255))) begin
                w_res[ch] = 8'd255;
            end else begin
                w_res[ch] = s[7:0];
            end
        end
    end

    assign o_adv = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_tok.valid && (i_tok.mode == gnpi_pkg::MODE_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_data.chan_a_out <= w_res[0];
            r_data.chan_b_out <= w_res[1];
            r_data.chan_c_out <= w_res[2];
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// ===== rtl/gaussian_noise_pixel_injector.sv =====
// an accepted pixel transaction passes one cell per table entry, then the output register, before
// its result appears; table writes travel the same row and give no result
// throughput: one transaction per cycle when not stalled, the row of 255 cells shifts as one pipeline
// a stall on the output freezes the whole row, so in-flight order is kept
// reset clears every valid flag at once; table entries are unknown until written
module gaussian_noise_pixel_injector (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gnpi_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output gnpi_pkg::t_out_item  o_out_data
);

    gnpi_pkg::t_token tok [0:gnpi_pkg::TABLE_LEN];
    gnpi_pkg::t_token w_head;
    logic             w_adv;

    always_comb begin
        w_head         = '0;
        w_head.valid   = i_in_valid;
        w_head.mode    = i_in_data.mode;
        w_head.idx     = i_in_data.entry_index;
        w_head.value   = i_in_data.entry_value;
        w_head.chan[0] = i_in_data.chan_a_in;
        w_head.chan[1] = i_in_data.chan_b_in;
        w_head.chan[2] = i_in_data.chan_c_in;
        w_head.rnd[0]  = i_in_data.rand_a;
        w_head.rnd[1]  = i_in_data.rand_b;
        w_head.rnd[2]  = i_in_data.rand_c;
        // maximum distance so the first entry is always taken
        w_head.best    = '1;
        w_head.done    = '0;
    end

    assign tok[0] = w_head;

    for (genvar k = 0; k < gnpi_pkg::TABLE_LEN; k++) begin : g_cell
        gnpi_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_adv),
            .i_cell_idx (gnpi_pkg::POS_W'(k)),
            .i_tok      (tok[k]),
            .o_tok      (tok[k+1])
        );
    end

    gnpi_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (tok[gnpi_pkg::TABLE_LEN]),
        .i_out_ready (i_out_ready),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_ready = w_adv;

    a_tail_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && tok[gnpi_pkg::TABLE_LEN].valid &&
         (tok[gnpi_pkg::TABLE_LEN].mode == gnpi_pkg::MODE_PIXEL)) |=> o_out_valid)
        else $error("pixel at end of row gave no result");

    a_first_cell_takes_entry0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok[1].valid && (tok[1].mode == gnpi_pkg::MODE_PIXEL)) |->
        ((tok[1].pos == '0) && (tok[1].done == '0)))
        else $error("first cell did not take entry zero");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!tok[gnpi_pkg::TABLE_LEN].valid && !o_out_valid && !tok[1].valid))
        else $error("valid flags not cleared by reset");

endmodule
